@@ sv/tspd_pkg.sv @@
// ----------------------------------------------------------------------------
// tspd_pkg: shared types and constants for the three-step phase decoder
// Holds the item format between front and back, widths and the CORDIC
// angle table in units of 2^-32 turn.
// ----------------------------------------------------------------------------
package tspd_pkg;

    localparam int SampleW       = 8;
    localparam int ValW          = 16;
    localparam int TableDepth    = 256;
    localparam int QueueDepth    = 4;
    localparam int QueuePtrW     = $clog2(QueueDepth);
    localparam int QueueCntW     = $clog2(QueueDepth + 1);
    localparam int CordicSteps   = 28;
    localparam int PhaseBitsDef  = 16;
    localparam int XyW           = 48;
    localparam int ZW            = 34;
    localparam int OutPhaseW     = 16;

    localparam logic [ValW-1:0]   RangeLimitRst = 16'd5120;
    localparam logic signed [25:0] Sqrt3Q24     = 26'sd29058991;
    localparam logic signed [ZW-1:0] QuarterTurn = 34'sd1073741824;

    // one queued item: decode flag plus the three corrected intensities
    typedef struct packed {
        logic            pixel;
        logic [ValW-1:0] va;
        logic [ValW-1:0] vb;
        logic [ValW-1:0] vc;
    } t_item;

    // atan(2^-i) in 2^-32 turn, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0:  v = 34'sd536870912;
                1:  v = 34'sd316933406;
                2:  v = 34'sd167458907;
                3:  v = 34'sd85004756;
                4:  v = 34'sd42667331;
                5:  v = 34'sd21354465;
                6:  v = 34'sd10679838;
                7:  v = 34'sd5340245;
                8:  v = 34'sd2670163;
                9:  v = 34'sd1335087;
                10: v = 34'sd667544;
                11: v = 34'sd333772;
                12: v = 34'sd166886;
                13: v = 34'sd83443;
                14: v = 34'sd41722;
                15: v = 34'sd20861;
                16: v = 34'sd10430;
                17: v = 34'sd5215;
                18: v = 34'sd2608;
                19: v = 34'sd1304;
                20: v = 34'sd652;
                21: v = 34'sd326;
                22: v = 34'sd163;
                23: v = 34'sd81;
                24: v = 34'sd41;
                25: v = 34'sd20;
                26: v = 34'sd10;
                27: v = 34'sd5;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ sv/tspd_front.sv @@
// ----------------------------------------------------------------------------
// tspd_front: input side and gamma table lookup
// Takes input transfers, writes table loads and reads the three corrected
// samples of a pixel from three copies of the gamma table.
// ----------------------------------------------------------------------------
module tspd_front
    import tspd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_cmd,
    input  logic [SampleW-1:0]   i_sample_first,
    input  logic [SampleW-1:0]   i_sample_second,
    input  logic [SampleW-1:0]   i_sample_third,
    input  logic [SampleW-1:0]   i_table_slot,
    input  logic [ValW-1:0]      i_table_value,
    input  logic [QueueCntW-1:0] i_q_count,
    output logic                 o_ready,
    output logic                 o_item_valid,
    output t_item                o_item
);

    // one copy per read port, all written alike
    logic [ValW-1:0] r_tab_a [TableDepth];
    logic [ValW-1:0] r_tab_b [TableDepth];
    logic [ValW-1:0] r_tab_c [TableDepth];

    logic            r_rd_valid;
    logic            r_rd_pixel;
    logic [ValW-1:0] r_rd_a;
    logic [ValW-1:0] r_rd_b;
    logic [ValW-1:0] r_rd_c;
    logic            acc;

    // credit check: queued items plus the one in the read stage
    assign o_ready = ({1'b0, i_q_count} + {{QueueCntW{1'b0}}, r_rd_valid})
                     < (QueueCntW+1)'(QueueDepth);
    assign acc = i_valid && o_ready;

    // table write and registered reads
    always_ff @(posedge i_clk) begin
        if (acc && !i_cmd) begin
            r_tab_a[i_table_slot] <= i_table_value;
            r_tab_b[i_table_slot] <= i_table_value;
            r_tab_c[i_table_slot] <= i_table_value;
        end
        if (acc) begin
            r_rd_a     <= r_tab_a[i_sample_first];
            r_rd_b     <= r_tab_b[i_sample_second];
            r_rd_c     <= r_tab_c[i_sample_third];
            r_rd_pixel <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= acc;
        end
    end

    assign o_item_valid = r_rd_valid;
    assign o_item       = '{pixel: r_rd_pixel, va: r_rd_a, vb: r_rd_b, vc: r_rd_c};

endmodule

@@ sv/tspd_queue.sv @@
// ----------------------------------------------------------------------------
// tspd_queue: short item queue between front and back
// Small register FIFO; the front never pushes when it is full.
// ----------------------------------------------------------------------------
module tspd_queue
    import tspd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_item                i_item,
    input  logic                 i_pop,
    output logic                 o_valid,
    output t_item                o_item,
    output logic [QueueCntW-1:0] o_count
);

    t_item                r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueueCntW-1:0] r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ sv/tspd_back.sv @@
// ----------------------------------------------------------------------------
// tspd_back: range, mask and CORDIC phase pipeline
// Min/max and mask, then sqrt3 scaling and quadrant fold, one CORDIC
// step per stage, rounding and the output register. Stalls as a whole.
// ----------------------------------------------------------------------------
module tspd_back
    import tspd_pkg::*;
#(
    parameter int PHASE_BITS = PhaseBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [ValW-1:0]      i_cfg_wr_data,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_pixel,
    output logic [OutPhaseW-1:0] o_phase,
    output logic [ValW-1:0]      o_range,
    output logic                 o_masked
);

    localparam int RndSh = 33 - PHASE_BITS;
    localparam int ShDn  = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
    localparam int ShUp  = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
    localparam logic signed [ZW-1:0] RndHalf = ZW'(64'sd1 <<< (RndSh - 1));

    logic [ValW-1:0] r_range_limit;
    logic            en;

    // stage A
    logic               r_a_valid, r_a_pixel, r_a_masked;
    logic [ValW-1:0]    r_a_range;
    logic signed [16:0] r_a_dac;
    logic signed [18:0] r_a_xp;

    // CORDIC stages, index 0 is the folded start vector
    logic                  r_c_valid  [CordicSteps+1];
    logic                  r_c_pixel  [CordicSteps+1];
    logic                  r_c_masked [CordicSteps+1];
    logic [ValW-1:0]       r_c_range  [CordicSteps+1];
    logic signed [XyW-1:0] r_c_x      [CordicSteps+1];
    logic signed [XyW-1:0] r_c_y      [CordicSteps+1];
    logic signed [ZW-1:0]  r_c_z      [CordicSteps+1];

    // output register
    logic                 r_out_valid, r_out_pixel, r_out_masked;
    logic [OutPhaseW-1:0] r_out_phase;
    logic [ValW-1:0]      r_out_range;

    assign en      = !r_out_valid || i_out_ready;
    assign o_q_pop = en && i_q_valid;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_limit <= RangeLimitRst;
        end else if (i_cfg_wr_en) begin
            r_range_limit <= i_cfg_wr_data;
        end
    end

    // stage A: range, mask and the two differences
    logic [ValW-1:0] hi, lo, rng;
    always_comb begin
        hi = i_q_item.va;
        lo = i_q_item.va;
        if (i_q_item.vb > hi) hi = i_q_item.vb;
        if (i_q_item.vc > hi) hi = i_q_item.vc;
        if (i_q_item.vb < lo) lo = i_q_item.vb;
        if (i_q_item.vc < lo) lo = i_q_item.vc;
        rng = hi - lo;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_pixel  <= i_q_item.pixel;
            r_a_range  <= rng;
            r_a_masked <= (rng <= r_range_limit);
            r_a_dac    <= $signed({1'b0, i_q_item.va}) - $signed({1'b0, i_q_item.vc});
            r_a_xp     <= $signed({2'b0, i_q_item.vb, 1'b0})
                          - $signed({3'b0, i_q_item.va}) - $signed({3'b0, i_q_item.vc});
        end
    end

    // stage B: scale by sqrt3 and fold into the right half plane
    logic signed [42:0]    y_prod;
    logic signed [XyW-1:0] x0, y0, fx, fy;
    logic signed [ZW-1:0]  fz;
    always_comb begin
        y_prod = r_a_dac * Sqrt3Q24;
        y0     = XyW'(y_prod);
        x0     = XyW'(r_a_xp) <<< 24;
        fx     = x0;
        fy     = y0;
        fz     = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                fx = y0;
                fy = -x0;
                fz = QuarterTurn;
            end else begin
                fx = -y0;
                fy = x0;
                fz = -QuarterTurn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_pixel[0]  <= r_a_pixel;
            r_c_masked[0] <= r_a_masked;
            r_c_range[0]  <= r_a_range;
            r_c_x[0]      <= fx;
            r_c_y[0]      <= fy;
            r_c_z[0]      <= fz;
        end
    end

    // vectoring steps, one per stage
    for (genvar gi = 0; gi < CordicSteps; gi++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c_pixel[gi+1]  <= r_c_pixel[gi];
                r_c_masked[gi+1] <= r_c_masked[gi];
                r_c_range[gi+1]  <= r_c_range[gi];
                if (r_c_y[gi] >= 0) begin
                    r_c_x[gi+1] <= r_c_x[gi] + (r_c_y[gi] >>> gi);
                    r_c_y[gi+1] <= r_c_y[gi] - (r_c_x[gi] >>> gi);
                    r_c_z[gi+1] <= r_c_z[gi] + atan_turn(gi);
                end else begin
                    r_c_x[gi+1] <= r_c_x[gi] - (r_c_y[gi] >>> gi);
                    r_c_y[gi+1] <= r_c_y[gi] + (r_c_x[gi] >>> gi);
                    r_c_z[gi+1] <= r_c_z[gi] - atan_turn(gi);
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            for (int k = 0; k <= CordicSteps; k++) r_c_valid[k] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid    <= i_q_valid;
            r_c_valid[0] <= r_a_valid;
            for (int k = 0; k < CordicSteps; k++) r_c_valid[k+1] <= r_c_valid[k];
            r_out_valid  <= r_c_valid[CordicSteps];
        end
    end

    // round to PHASE_BITS and place in Q1.15
    logic signed [ZW-1:0] q_rnd, q_out;
    always_comb begin
        q_rnd = (r_c_z[CordicSteps] + RndHalf) >>> RndSh;
        q_out = (q_rnd >>> ShDn) <<< ShUp;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pixel  <= r_c_pixel[CordicSteps];
            r_out_range  <= r_c_pixel[CordicSteps] ? r_c_range[CordicSteps] : '0;
            r_out_masked <= r_c_pixel[CordicSteps] && r_c_masked[CordicSteps];
            r_out_phase  <= (r_c_pixel[CordicSteps] && !r_c_masked[CordicSteps])
                            ? q_out[OutPhaseW-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out_pixel;
    assign o_phase     = r_out_phase;
    assign o_range     = r_out_range;
    assign o_masked    = r_out_masked;

`ifndef SYNTHESIS
    a_load_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pixel |-> o_phase == '0 && o_range == '0 && !o_masked)
        else $error("load acknowledge carries nonzero fields");
    a_masked_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_masked |-> o_phase == '0)
        else $error("masked pixel with nonzero phase");
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("pop from empty queue");
    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_valid)
        else $error("output valid after reset");
`endif

endmodule

@@ sv/three_step_phase_decoder.sv @@
// ----------------------------------------------------------------------------
// three_step_phase_decoder: wrapped phase from three phase-shifted samples
// Path: table read register, queue, range stage, fold stage, CORDIC stages,
//   output register. Throughput: one item per cycle while the output is not
//   stalled; every stage is fully pipelined.
// Reset clears all control and sets range_limit to 5120; the gamma table
//   is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module three_step_phase_decoder
    import tspd_pkg::*;
#(
    parameter int PHASE_BITS = PhaseBitsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [ValW-1:0] i_cfg_wr_data,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    // [7:0] sample_first, [15:8] sample_second, [23:16] sample_third,
    // [31:24] table_slot, [47:32] table_value
    input  logic [47:0]     i_s_axis_tdata,
    // [0] cmd
    input  logic            i_s_axis_tuser,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    // [15:0] wrapped_phase, [31:16] intensity_range, [32] masked, rest zero
    output logic [39:0]     o_m_axis_tdata,
    // [0] pixel_done
    output logic            o_m_axis_tuser
);

    logic                 fr_valid;
    t_item                fr_item;
    logic                 q_valid, q_pop;
    t_item                q_item;
    logic [QueueCntW-1:0] q_count;
    logic [OutPhaseW-1:0] phase;
    logic [ValW-1:0]      range_v;
    logic                 masked;

    tspd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .i_cmd           (i_s_axis_tuser),
        .i_sample_first  (i_s_axis_tdata[7:0]),
        .i_sample_second (i_s_axis_tdata[15:8]),
        .i_sample_third  (i_s_axis_tdata[23:16]),
        .i_table_slot    (i_s_axis_tdata[31:24]),
        .i_table_value   (i_s_axis_tdata[47:32]),
        .i_q_count       (q_count),
        .o_ready         (o_s_axis_tready),
        .o_item_valid    (fr_valid),
        .o_item          (fr_item)
    );

    tspd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_item  (fr_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    tspd_back #(
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_pixel       (o_m_axis_tuser),
        .o_phase       (phase),
        .o_range       (range_v),
        .o_masked      (masked)
    );

    assign o_m_axis_tdata = {7'd0, masked, range_v, phase};

endmodule

@@ tb/three_step_phase_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_step_phase_decoder_test: self-checking bench for the phase decoder
// Loads gamma tables through the input stream, decodes pixels under several
// mask thresholds and compares every output transfer with a software
// predictor of the CORDIC phase, the intensity range and the mask flag.
// ----------------------------------------------------------------------------
module three_step_phase_decoder_test;
    import tspd_pkg::*;

    localparam logic CmdLoad   = 1'b0;
    localparam logic CmdDecode = 1'b1;
    localparam int   DirRows   = 20;

    typedef struct packed {
        logic        pix;
        logic [15:0] phase;
        logic [15:0] rng;
        logic        msk;
    } t_result;

    typedef struct {
        logic        cmd;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  slot;
        logic [15:0] val;
        bit          typed;   // expected result typed in below
        t_result     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    // predictor state
    logic [15:0] gamma_copy [256];
    bit          gamma_known [256];
    logic [15:0] limit_copy;
    t_result     pending_results [$];
    int          fail_count;
    int          known_slots [$];

    three_step_phase_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    // CORDIC vectoring phase of (2b-a-c, sqrt3*(a-c)) in Q1.15 turns
    function automatic logic [15:0] cordic_phase(longint a, longint b, longint c);
        longint x, y, z, t, xs, ys, q;
        x = (2 * b - a - c) * 64'sd16777216;
        y = (a - c) * 64'sd29058991;
        z = 0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 64'sd1073741824;
            end else begin
                t = x; x = -y; y = t; z = -64'sd1073741824;
            end
        end
        for (int i = 0; i < 28; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += longint'(atan_turn(i));
            end else begin
                x = x - ys; y = y + xs; z -= longint'(atan_turn(i));
            end
        end
        q = floor_sh(z + (64'sd1 <<< 16), 17);
        return q[15:0];
    endfunction

    // expected result of one input transfer; updates the table copy
    function automatic t_result decode_pixel(logic cmd, logic [7:0] a, logic [7:0] b,
                                             logic [7:0] c, logic [7:0] slot,
                                             logic [15:0] val);
        t_result r;
        logic [15:0] va, vb, vc, hi, lo;
        r = '{default: '0};
        if (cmd == CmdLoad) begin
            gamma_copy[slot] = val;
            if (!gamma_known[slot]) known_slots.push_back(slot);
            gamma_known[slot] = 1'b1;
            return r;
        end
        va = gamma_copy[a]; vb = gamma_copy[b]; vc = gamma_copy[c];
        hi = va; lo = va;
        if (vb > hi) hi = vb;
        if (vc > hi) hi = vc;
        if (vb < lo) lo = vb;
        if (vc < lo) lo = vc;
        r.pix = 1'b1;
        r.rng = hi - lo;
        r.msk = r.rng <= limit_copy;
        if (!r.msk) r.phase = cordic_phase(va, vb, vc);
        return r;
    endfunction

    // one input transfer, with random gaps before it
    task automatic send_item(logic cmd, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                             logic [7:0] slot, logic [15:0] val, bit typed,
                             t_result res);
        t_result r;
        int gap;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {val, slot, c, b, a};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        r = decode_pixel(cmd, a, b, c, slot, val);
        if (typed && r != res) begin
            $error("typed row disagrees with predictor");
            fail_count++;
        end
        pending_results.push_back(typed ? res : r);
    endtask

    task automatic drain_and_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_copy = v;
    endtask

    function automatic logic [7:0] pick_known();
        return 8'(known_slots[$urandom_range(0, known_slots.size() - 1)]);
    endfunction

    // output side: random stalls and field checks
    initial begin
        t_result want;
        int stall;
        i_m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                    $urandom_range(1, 3);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                $error("output transfer with no result expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser !== want.pix) begin
                    $error("pixel_done: expected %0h got %0h", want.pix, o_m_axis_tuser);
                    fail_count++;
                end
                if (o_m_axis_tdata[15:0] !== want.phase) begin
                    $error("wrapped_phase: expected %0h got %0h", want.phase,
                           o_m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[31:16] !== want.rng) begin
                    $error("intensity_range: expected %0h got %0h", want.rng,
                           o_m_axis_tdata[31:16]);
                    fail_count++;
                end
                if (o_m_axis_tdata[32] !== want.msk) begin
                    $error("masked: expected %0h got %0h", want.msk, o_m_axis_tdata[32]);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_row rows [DirRows];
        t_result z;
        logic [15:0] limits [5];
        fail_count = 0;
        limit_copy = RangeLimitRst;
        foreach (gamma_known[i]) gamma_known[i] = 1'b0;
        z = '{default: '0};
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tuser <= CmdLoad;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: loads ack with zeros; table extremes; special phases
        rows[0]  = '{CmdLoad, 0, 0, 0, 8'd0,   16'd0,     1, z};
        rows[1]  = '{CmdLoad, 0, 0, 0, 8'd255, 16'hFFFF,  1, z};
        rows[2]  = '{CmdLoad, 0, 0, 0, 8'd10,  16'd5120,  1, z};
        rows[3]  = '{CmdLoad, 0, 0, 0, 8'd11,  16'd5121,  1, z};
        rows[4]  = '{CmdLoad, 0, 0, 0, 8'd128, 16'h8000,  1, z};
        rows[5]  = '{CmdLoad, 0, 0, 0, 8'd64,  16'h4000,  1, z};
        rows[6]  = '{CmdLoad, 0, 0, 0, 8'd200, 16'hFF00,  1, z};
        // all equal: zero vector, masked, zero range
        rows[7]  = '{CmdDecode, 8'd0, 8'd0, 8'd0, 0, 0, 1, '{1'b1, 16'd0, 16'd0, 1'b1}};
        // range right at the threshold is masked
        rows[8]  = '{CmdDecode, 8'd0, 8'd10, 8'd0, 0, 0, 1,
                     '{1'b1, 16'd0, 16'd5120, 1'b1}};
        // one above: decoded by predictor
        rows[9]  = '{CmdDecode, 8'd0, 8'd11, 8'd0, 0, 0, 0, z};
        // negative x axis: a=c, 2b<a+c gives half a turn
        rows[10] = '{CmdDecode, 8'd255, 8'd0, 8'd255, 0, 0, 1,
                     '{1'b1, 16'h4000, 16'hFFFF, 1'b0}};
        rows[11] = '{CmdDecode, 8'd255, 8'd0, 8'd0, 0, 0, 0, z};
        rows[12] = '{CmdDecode, 8'd0, 8'd0, 8'd255, 0, 0, 0, z};
        rows[13] = '{CmdDecode, 8'd0, 8'd255, 8'd0, 0, 0, 0, z};
        rows[14] = '{CmdDecode, 8'd128, 8'd64, 8'd200, 0, 0, 0, z};
        rows[15] = '{CmdDecode, 8'd200, 8'd128, 8'd64, 0, 0, 0, z};
        rows[16] = '{CmdDecode, 8'd64, 8'd255, 8'd128, 0, 0, 0, z};
        rows[17] = '{CmdDecode, 8'd255, 8'd200, 8'd0, 0, 0, 0, z};
        rows[18] = '{CmdDecode, 8'd11, 8'd255, 8'd11, 0, 0, 0, z};
        rows[19] = '{CmdDecode, 8'd0, 8'd128, 8'd128, 0, 0, 0, z};
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].a, rows[i].b, rows[i].c, rows[i].slot,
                      rows[i].val, rows[i].typed, rows[i].res);

        // random phases, each under its own threshold
        limits = '{16'd0, 16'hFFFF, 16'd256, 16'd12000, RangeLimitRst};
        foreach (limits[p]) begin
            drain_and_idle();
            write_limit(limits[p]);
            for (int n = 0; n < 390; n++) begin
                if ($urandom_range(0, 9) < 2)
                    send_item(CmdLoad, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom),
                              ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                              16'($urandom_range(0, 65280)), 0, z);
                else
                    send_item(CmdDecode, pick_known(), pick_known(), pick_known(),
                              8'($urandom), 16'($urandom), 0, z);
            end
        end

        drain_and_idle();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
